/* rtl/core/gradient_stop_colormap_unit_assert.svh */
// ----------------------------------------------------------------------------
// gradient_stop_colormap_unit_assert.svh
// Assertion macros shared by the colormap unit; ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_STOP_COLORMAP_UNIT_ASSERT_SVH
`define GRADIENT_STOP_COLORMAP_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle, quiet during reset
`define GSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gsc assertion failed");
// consequent holds in the cycle after any reset cycle
`define GSC_ASSERT_AFTER_RST(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("gsc assertion failed");
`else
`define GSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GSC_ASSERT_AFTER_RST(label, clk, rst_n, cons)
`endif
`endif

/* rtl/core/gsc_pkg.sv */
// ----------------------------------------------------------------------------
// gsc_pkg
// Widths, stop register layout and stage payload types of the colormap unit.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int LEVEL_W   = 8;
    localparam int CHAN_W    = 8;
    localparam int POS_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int RGB_W     = 3 * CHAN_W;
    localparam int REG_W     = 1 + POS_W + RGB_W;
    localparam int CFG_IDX_W = 4;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(1 << FRAC_W);

    // divider: dividend is |q - p1| with 16 fraction bits appended
    localparam int DIV_W      = POS_W + FRAC_W;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    // blend arithmetic
    localparam int T_W    = DIV_W + 1;
    localparam int DIFF_W = CHAN_W + 1;
    localparam int PROD_W = T_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  pos;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_stop;

    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [RGB_W-1:0] c1;
        logic [RGB_W-1:0] c2;
    } t_div_side;

    typedef struct packed {
        logic [POS_W-1:0] num;
        logic [POS_W-1:0] den;
        t_div_side        side;
    } t_div_req;

    typedef struct packed {
        logic [DIV_W-1:0] quo;
        t_div_side        side;
    } t_div_rsp;

    function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] p);
        return (p > POS_MAX) ? POS_MAX : p;
    endfunction

    function automatic logic [RGB_W-1:0] stop_rgb(input t_stop s);
        return {s.red, s.green, s.blue};
    endfunction

endpackage

/* rtl/core/gsc_seg.sv */
// ----------------------------------------------------------------------------
// gsc_seg
// Segment search over the enabled stops and fetch of the segment end points.
// ----------------------------------------------------------------------------
module gsc_seg #(
    parameter int STOP_COUNT = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gsc_pkg::t_stop              i_stop [STOP_COUNT],
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [gsc_pkg::LEVEL_W-1:0] i_level,
    output logic                        o_valid,
    input  logic                        i_ready,
    output gsc_pkg::t_div_req           o_req
);

    localparam int SIW = $clog2(STOP_COUNT);

    logic [gsc_pkg::POS_W-1:0] w_pos [STOP_COUNT];
    logic [STOP_COUNT-1:0]     w_run;
    logic [gsc_pkg::POS_W-1:0] w_q;
    logic [SIW-1:0]            w_a;
    logic [SIW-1:0]            w_b;
    logic                      w_found;
    logic                      w_rdy1;
    logic                      w_rdy2;

    logic                      r1_v;
    logic [gsc_pkg::POS_W-1:0] r1_q;
    logic [SIW-1:0]            r1_a;
    logic [SIW-1:0]            r1_b;
    logic                      r1_none;

    logic [gsc_pkg::POS_W-1:0] w_p1;
    logic [gsc_pkg::POS_W-1:0] w_p2;
    logic [gsc_pkg::POS_W:0]   w_diff;
    gsc_pkg::t_div_req         n_req;

    logic                      r2_v;
    gsc_pkg::t_div_req         r2_req;

    // level * 65536 / 255 is level * 257, plus one at full scale
    assign w_q = (&i_level) ? gsc_pkg::POS_MAX : {1'b0, i_level, i_level};

    always_comb begin
        for (int k = 0; k < STOP_COUNT; k++) begin
            w_pos[k] = gsc_pkg::sat_pos(i_stop[k].pos);
        end
        w_run[0] = i_stop[0].en;
        for (int k = 1; k < STOP_COUNT; k++) begin
            w_run[k] = w_run[k-1] & i_stop[k].en;
        end
        // fallback pair: first and last stop of the leading enabled run
        w_a     = '0;
        w_b     = '0;
        w_found = 1'b0;
        for (int k = 0; k < STOP_COUNT; k++) begin
            if (w_run[k]) begin
                w_b = SIW'(k);
            end
        end
        for (int j = 0; j < STOP_COUNT - 1; j++) begin
            if (!w_found && w_run[j+1] && (w_q >= w_pos[j]) && (w_q <= w_pos[j+1])) begin
                w_a     = SIW'(j);
                w_b     = SIW'(j + 1);
                w_found = 1'b1;
            end
        end
    end

    assign w_rdy2  = !r2_v || i_ready;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_rdy1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_q    <= w_q;
            r1_a    <= w_a;
            r1_b    <= w_b;
            r1_none <= !w_run[0];
        end
    end

    always_comb begin
        w_p1   = w_pos[r1_a];
        w_p2   = w_pos[r1_b];
        w_diff = {1'b0, r1_q} - {1'b0, w_p1};
        n_req.side.neg  = w_diff[gsc_pkg::POS_W];
        n_req.num       = w_diff[gsc_pkg::POS_W] ? gsc_pkg::POS_W'(-w_diff)
                                                 : w_diff[gsc_pkg::POS_W-1:0];
        n_req.den       = w_p2 - w_p1;
        n_req.side.zero = r1_none || !(w_p2 > w_p1);
        n_req.side.c1   = r1_none ? '0 : gsc_pkg::stop_rgb(i_stop[r1_a]);
        n_req.side.c2   = r1_none ? '0 : gsc_pkg::stop_rgb(i_stop[r1_b]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_rdy2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r1_v) begin
            r2_req <= n_req;
        end
    end

    assign o_valid = r2_v;
    assign o_req   = r2_req;

endmodule

/* rtl/core/gsc_div.sv */
// ----------------------------------------------------------------------------
// gsc_div
// Pipelined restoring divider for the interpolation fraction.
// ----------------------------------------------------------------------------
module gsc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gsc_pkg::t_div_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output gsc_pkg::t_div_rsp o_rsp
);

    localparam int LAST = gsc_pkg::DIV_STAGES - 1;

    logic                      r_v    [gsc_pkg::DIV_STAGES];
    logic [gsc_pkg::DIV_W-1:0] r_work [gsc_pkg::DIV_STAGES];
    logic [gsc_pkg::POS_W-1:0] r_rem  [gsc_pkg::DIV_STAGES];
    logic [gsc_pkg::POS_W-1:0] r_den  [gsc_pkg::DIV_STAGES];
    gsc_pkg::t_div_side        r_side [gsc_pkg::DIV_STAGES];
    logic                      w_rdy  [gsc_pkg::DIV_STAGES + 1];

    assign w_rdy[gsc_pkg::DIV_STAGES] = i_ready;

    for (genvar s = 0; s < gsc_pkg::DIV_STAGES; s++) begin : g_stage
        logic                      w_in_v;
        logic [gsc_pkg::DIV_W-1:0] w_in_work;
        logic [gsc_pkg::POS_W-1:0] w_in_rem;
        logic [gsc_pkg::POS_W-1:0] w_in_den;
        gsc_pkg::t_div_side        w_in_side;
        logic [gsc_pkg::POS_W:0]   w_trial;
        logic [gsc_pkg::DIV_W-1:0] n_work;
        logic [gsc_pkg::POS_W-1:0] n_rem;

        if (s == 0) begin : g_first
            assign w_in_v    = i_valid;
            assign w_in_work = {i_req.num, {gsc_pkg::FRAC_W{1'b0}}};
            assign w_in_rem  = '0;
            assign w_in_den  = i_req.den;
            assign w_in_side = i_req.side;
        end else begin : g_next
            assign w_in_v    = r_v[s-1];
            assign w_in_work = r_work[s-1];
            assign w_in_rem  = r_rem[s-1];
            assign w_in_den  = r_den[s-1];
            assign w_in_side = r_side[s-1];
        end

        // dividend bits leave at the top of the work word, quotient bits enter below
        always_comb begin
            n_work  = w_in_work;
            n_rem   = w_in_rem;
            w_trial = '0;
            for (int i = 0; i < gsc_pkg::DIV_STEP; i++) begin
                w_trial = {n_rem, n_work[gsc_pkg::DIV_W-1]};
                if (w_trial >= {1'b0, w_in_den}) begin
                    n_rem  = gsc_pkg::POS_W'(w_trial - {1'b0, w_in_den});
                    n_work = {n_work[gsc_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_trial[gsc_pkg::POS_W-1:0];
                    n_work = {n_work[gsc_pkg::DIV_W-2:0], 1'b0};
                end
            end
        end

        assign w_rdy[s] = !r_v[s] || w_rdy[s+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_v[s] <= w_in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_in_v) begin
                r_work[s] <= n_work;
                r_rem[s]  <= n_rem;
                r_den[s]  <= w_in_den;
                r_side[s] <= w_in_side;
            end
        end
    end

    assign o_ready    = w_rdy[0];
    assign o_valid    = r_v[LAST];
    assign o_rsp.quo  = r_work[LAST];
    assign o_rsp.side = r_side[LAST];

endmodule

/* rtl/core/gsc_blend.sv */
// ----------------------------------------------------------------------------
// gsc_blend
// Signed fraction, per-channel multiply, truncate and clamp, output register.
// ----------------------------------------------------------------------------
module gsc_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  gsc_pkg::t_div_rsp          i_rsp,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [gsc_pkg::CHAN_W-1:0] o_red,
    output logic [gsc_pkg::CHAN_W-1:0] o_green,
    output logic [gsc_pkg::CHAN_W-1:0] o_blue
);

    localparam int HI = gsc_pkg::FRAC_W + gsc_pkg::CHAN_W;

    logic                               w_rdy1;
    logic                               w_rdy2;
    logic                               w_rdy3;

    logic signed [gsc_pkg::T_W-1:0]     w_mag;
    logic signed [gsc_pkg::T_W-1:0]     w_t;
    logic signed [gsc_pkg::DIFF_W-1:0]  w_d   [3];

    logic                               r1_v;
    logic signed [gsc_pkg::T_W-1:0]     r1_t;
    logic signed [gsc_pkg::DIFF_W-1:0]  r1_d  [3];
    logic [gsc_pkg::RGB_W-1:0]          r1_c1;

    logic                               r2_v;
    logic signed [gsc_pkg::PROD_W-1:0]  r2_prod [3];
    logic [gsc_pkg::RGB_W-1:0]          r2_c1;

    logic signed [gsc_pkg::SUM_W-1:0]   w_base [3];
    logic signed [gsc_pkg::SUM_W-1:0]   w_sum  [3];
    logic [gsc_pkg::RGB_W-1:0]          n_rgb;

    logic                               r3_v;
    logic [gsc_pkg::RGB_W-1:0]          r3_rgb;

    assign w_rdy3  = !r3_v || i_ready;
    assign w_rdy2  = !r2_v || w_rdy3;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_ready = w_rdy1;

    // quotient is a magnitude; sign comes from q - p1
    always_comb begin
        w_mag = $signed({1'b0, i_rsp.quo});
        if (i_rsp.side.zero) begin
            w_t = '0;
        end else if (i_rsp.side.neg) begin
            w_t = -w_mag;
        end else begin
            w_t = w_mag;
        end
        for (int c = 0; c < 3; c++) begin
            w_d[c] = $signed({1'b0, i_rsp.side.c2[(2-c)*gsc_pkg::CHAN_W +: gsc_pkg::CHAN_W]})
                   - $signed({1'b0, i_rsp.side.c1[(2-c)*gsc_pkg::CHAN_W +: gsc_pkg::CHAN_W]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_v <= i_valid;
            end
            if (w_rdy2) begin
                r2_v <= r1_v;
            end
            if (w_rdy3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_t  <= w_t;
            r1_d  <= w_d;
            r1_c1 <= i_rsp.side.c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r1_v) begin
            for (int c = 0; c < 3; c++) begin
                r2_prod[c] <= r1_t * r1_d[c];
            end
            r2_c1 <= r1_c1;
        end
    end

    // negative sums clamp to zero, so truncation direction only matters above
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_base[c] = $signed({{(gsc_pkg::SUM_W - HI){1'b0}},
                                 r2_c1[(2-c)*gsc_pkg::CHAN_W +: gsc_pkg::CHAN_W],
                                 {gsc_pkg::FRAC_W{1'b0}}});
            w_sum[c]  = w_base[c] + gsc_pkg::SUM_W'(r2_prod[c]);
            if (w_sum[c][gsc_pkg::SUM_W-1]) begin
                n_rgb[(2-c)*gsc_pkg::CHAN_W +: gsc_pkg::CHAN_W] = '0;
            end else if (|w_sum[c][gsc_pkg::SUM_W-2:HI]) begin
                n_rgb[(2-c)*gsc_pkg::CHAN_W +: gsc_pkg::CHAN_W] = '1;
            end else begin
                n_rgb[(2-c)*gsc_pkg::CHAN_W +: gsc_pkg::CHAN_W] =
                    w_sum[c][HI-1:gsc_pkg::FRAC_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r2_v) begin
            r3_rgb <= n_rgb;
        end
    end

    assign o_valid = r3_v;
    assign o_red   = r3_rgb[3*gsc_pkg::CHAN_W-1:2*gsc_pkg::CHAN_W];
    assign o_green = r3_rgb[2*gsc_pkg::CHAN_W-1:gsc_pkg::CHAN_W];
    assign o_blue  = r3_rgb[gsc_pkg::CHAN_W-1:0];

endmodule

/* rtl/core/gradient_stop_colormap_unit.sv */
// ----------------------------------------------------------------------------
// gradient_stop_colormap_unit
// Maps an 8-bit level to RGB by linear interpolation between color stops.
// ----------------------------------------------------------------------------
// Takes one level per clock while o_stall is low and passes it through the
// segment search and end point fetch registers, eleven divider stages that
// each retire three bits of the 33-bit fraction, then fraction sign, multiply
// and clamp, the last of these being the output register. A stalled output
// only backs up the stages that hold data, so requests are still taken while
// the pipeline has bubbles.
// Stop registers are written through the plain write port and must only be
// changed while no request is in flight; writes to an index of STOP_COUNT or
// above are dropped.
`include "gradient_stop_colormap_unit_assert.svh"

module gradient_stop_colormap_unit #(
    parameter int STOP_COUNT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gsc_pkg::REG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [gsc_pkg::LEVEL_W-1:0]   i_level,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gsc_pkg::CHAN_W-1:0]    o_red,
    output logic [gsc_pkg::CHAN_W-1:0]    o_green,
    output logic [gsc_pkg::CHAN_W-1:0]    o_blue
);

    localparam int SIW = $clog2(STOP_COUNT);

    gsc_pkg::t_stop    r_stop [STOP_COUNT];

    logic              w_in_ready;
    logic              w_seg_v;
    logic              w_seg_ready;
    gsc_pkg::t_div_req w_seg_req;
    logic              w_div_v;
    logic              w_div_ready;
    gsc_pkg::t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STOP_COUNT; k++) begin
                r_stop[k] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < gsc_pkg::CFG_IDX_W'(STOP_COUNT))) begin
            r_stop[i_cfg_idx[SIW-1:0]] <= gsc_pkg::t_stop'(i_cfg_data);
        end
    end

    gsc_seg #(
        .STOP_COUNT (STOP_COUNT)
    ) u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stop  (r_stop),
        .i_valid (i_valid),
        .o_ready (w_in_ready),
        .i_level (i_level),
        .o_valid (w_seg_v),
        .i_ready (w_seg_ready),
        .o_req   (w_seg_req)
    );

    gsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seg_v),
        .o_ready (w_seg_ready),
        .i_req   (w_seg_req),
        .o_valid (w_div_v),
        .i_ready (w_div_ready),
        .o_rsp   (w_div_rsp)
    );

    gsc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_v),
        .o_ready (w_div_ready),
        .i_rsp   (w_div_rsp),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    assign o_stall = !w_in_ready;

    // with nothing at the output every stage can move, so no request is held off
    `GSC_ASSERT_IMPL(a_idle_no_stall, i_clk, i_rst_n, !o_valid, !o_stall)
    // a rising segment always hands the divider a nonzero divisor
    `GSC_ASSERT_IMPL(a_den_nonzero, i_clk, i_rst_n, w_seg_v && !w_seg_req.side.zero, w_seg_req.den != '0)
    `GSC_ASSERT_AFTER_RST(a_reset_clear, i_clk, i_rst_n, !o_valid && (r_stop[0] == '0))

endmodule
